// ===== rtl/ygbd_pkg.sv =====
// Shared types and constants of the YOLO grid box decode unit.
`default_nettype none

package ygbd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned COORD_W    = 29;
  localparam int unsigned BOXNO_W    = 10;
  localparam int unsigned CLASSNO_W  = 5;
  localparam int unsigned CLSCNT_W   = 6;
  localparam int unsigned BPC_W      = 3;
  localparam int unsigned GSIDE_W    = 5;
  localparam int unsigned IMG_W      = 13;
  localparam int unsigned BOXIDX_W   = 2;

  // Quotient bits retired per cycle by the divider.
  localparam int unsigned DIV_STEPS  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_COUNT     = 3'd0,
    REG_BOXES_PER_CELL  = 3'd1,
    REG_GRID_SIDE       = 3'd2,
    REG_SQUARE_MODE     = 3'd3,
    REG_THRESHOLD       = 3'd4,
    REG_IMAGE_WIDTH     = 3'd5,
    REG_IMAGE_HEIGHT    = 3'd6,
    REG_ONLY_OBJECTNESS = 3'd7
  } cfg_reg_e;

  localparam logic [CLSCNT_W-1:0] RST_CLASS_COUNT    = 6'd20;
  localparam logic [BPC_W-1:0]    RST_BOXES_PER_CELL = 3'd2;
  localparam logic [GSIDE_W-1:0]  RST_GRID_SIDE      = 5'd7;
  localparam logic                RST_SQUARE_MODE    = 1'b1;
  localparam logic [VAL_W-1:0]    RST_THRESHOLD      = 16'd19661;
  localparam logic [IMG_W-1:0]    RST_IMAGE_WIDTH    = 13'd1;
  localparam logic [IMG_W-1:0]    RST_IMAGE_HEIGHT   = 13'd1;
  localparam logic                RST_ONLY_OBJ       = 1'b0;

  // Control of one divider run.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ygbd_div.sv =====
// Radix-16 restoring divider of a wide dividend by a narrow divisor.
`default_nettype none

module ygbd_div import ygbd_pkg::*; #(
  parameter int unsigned W  = 37,
  parameter int unsigned DW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire div_ctrl_t     ctrl_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output      logic          done_o,
  output      logic [W-1:0]  quotient_o,
  output      logic [DW-1:0] remainder_o
);

  localparam int unsigned ITER  = (W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned PW    = ITER * DIV_STEPS;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic [PW-1:0]    shreg_q, shreg_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DW:0]      trial;

  // Shift in DIV_STEPS dividend bits, subtract where the partial remainder allows.
  always_comb begin
    rem_d   = rem_q;
    shreg_d = shreg_q;
    trial   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial   = {rem_d, shreg_d[PW-1]};
      shreg_d = {shreg_d[PW-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial      = trial - {1'b0, div_q};
        shreg_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ITER);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      shreg_q <= PW'(dividend_i);
      rem_q   <= '0;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      shreg_q <= shreg_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = shreg_q[W-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/yolo_grid_box_decode_unit.sv =====
// Usage:
//   Input channel (in_valid_i/in_ready_o): command 0 stores the next class
//   probability of the current cell in the class buffer; command 1 is a box
//   request and produces one result per class in use.
//   Output channel (out_valid_o/out_ready_i): results leave an output register
//   in class order; last_o marks the final class of a box.
//   Config channel (cfg_valid_i/cfg_ready_o): always ready, write only while
//   no request is in flight.
// Steps of a box request: the accept, the cell row/column division, a
//   multiply step, the centre division, then class_count reads of the class
//   buffer at one per cycle while the receiver does not stall, and a drain of
//   the read and multiply stages. The radix-16 dividers and the single buffer
//   read port set its length.
// The next request is taken while the last result still waits in the output
//   register. A stalled receiver freezes the read/multiply pipeline in place.
// Reset: registers take their documented defaults, cell and box counters
//   clear; class buffer contents are undefined until loaded.
`default_nettype none

module yolo_grid_box_decode_unit import ygbd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 32,
  parameter int unsigned MAX_SIDE    = 16,
  parameter int unsigned MAX_BOXES   = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  command_i,
  input  wire logic [VAL_W-1:0]      class_prob_i,
  input  wire logic [VAL_W-1:0]      objectness_i,
  input  wire logic [VAL_W-1:0]      offset_x_i,
  input  wire logic [VAL_W-1:0]      offset_y_i,
  input  wire logic [VAL_W-1:0]      raw_width_i,
  input  wire logic [VAL_W-1:0]      raw_height_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [BOXNO_W-1:0]    box_number_o,
  output      logic [COORD_W-1:0]    centre_x_o,
  output      logic [COORD_W-1:0]    centre_y_o,
  output      logic [COORD_W-1:0]    box_width_o,
  output      logic [COORD_W-1:0]    box_height_o,
  output      logic [CLASSNO_W-1:0]  class_number_o,
  output      logic [VAL_W-1:0]      probability_o,
  output      logic                  last_o
);

  localparam int unsigned CIW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned LCW     = $clog2(MAX_CLASSES + 1);
  localparam int unsigned NCL_MAX = (MAX_CLASSES < 32) ? MAX_CLASSES : 32;
  localparam int unsigned SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CELL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
  localparam int unsigned NUM_W   = CELL_W + VAL_W;
  localparam int unsigned PROD_W  = NUM_W + IMG_W;
  localparam int unsigned SZ_W    = 2 * VAL_W;
  localparam int unsigned SZP_W   = SZ_W + IMG_W;
  localparam int unsigned BN_W    = CELL_W + BPC_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CELL, ST_MUL, ST_XY, ST_EMIT, ST_DRAIN
  } state_e;

  // Configuration registers
  logic [CLSCNT_W-1:0] class_count_q;
  logic [BPC_W-1:0]    boxes_per_cell_q;
  logic [GSIDE_W-1:0]  grid_side_q;
  logic                square_mode_q;
  logic [VAL_W-1:0]    threshold_q;
  logic [IMG_W-1:0]    image_width_q;
  logic [IMG_W-1:0]    image_height_q;
  logic                only_obj_q;

  // Control state
  state_e               state_q;
  logic [LCW-1:0]       load_cnt_q;
  logic [BOXIDX_W-1:0]  box_idx_q;
  logic [CELL_W-1:0]    cell_q;
  logic [CLASSNO_W-1:0] j_q;
  logic                 s1_v_q, s2_v_q, out_v_q;

  // Box datapath
  logic [VAL_W-1:0]     scale_q, offx_q, offy_q, rawh_q, raww_q;
  logic [BOXNO_W-1:0]   box_no_q;
  logic [PROD_W-1:0]    numx_q, numy_q;
  logic [SZ_W-1:0]      szw_q, szh_q;
  logic [COORD_W-1:0]   cx_q, cy_q, bw_q, bh_q;
  logic [CLASSNO_W-1:0] s1_j_q, s2_j_q;
  logic                 s1_last_q, s2_last_q;
  logic [SZ_W-1:0]      prod_q;
  logic [VAL_W-1:0]     rd_data_q;

  // Output register
  logic [BOXNO_W-1:0]   o_box_no_q;
  logic [COORD_W-1:0]   o_cx_q, o_cy_q, o_bw_q, o_bh_q;
  logic [CLASSNO_W-1:0] o_cls_q;
  logic [VAL_W-1:0]     o_prob_q;
  logic                 o_last_q;

  logic [VAL_W-1:0] class_mem [MAX_CLASSES];

  // Effective (clamped) configuration
  logic [CLSCNT_W-1:0] n_class;
  logic [BPC_W-1:0]    n_box;
  logic [SIDE_W-1:0]   side;

  always_comb begin
    if (class_count_q == '0) n_class = CLSCNT_W'(1);
    else if (class_count_q > CLSCNT_W'(NCL_MAX)) n_class = CLSCNT_W'(NCL_MAX);
    else n_class = class_count_q;

    if (boxes_per_cell_q == '0) n_box = BPC_W'(1);
    else if (boxes_per_cell_q > BPC_W'(MAX_BOXES)) n_box = BPC_W'(MAX_BOXES);
    else n_box = boxes_per_cell_q;

    if (grid_side_q == '0) side = SIDE_W'(1);
    else if (grid_side_q > GSIDE_W'(MAX_SIDE)) side = SIDE_W'(MAX_SIDE);
    else side = SIDE_W'(grid_side_q);
  end

  logic in_acc, box_acc, cls_acc, cfg_acc, adv, last_issue;
  logic box_wrap;
  logic [CELL_W:0]   cell_inc;
  logic [CELL_W:0]   cell_total;
  logic [BN_W-1:0]   box_no_full;
  logic [VAL_W-1:0]  prob_raw, prob_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign box_acc     = in_acc & command_i;
  assign cls_acc     = in_acc & ~command_i;
  assign adv         = ~out_v_q | out_ready_i;
  assign last_issue  = (CLSCNT_W'(j_q) + CLSCNT_W'(1)) == n_class;

  assign box_wrap    = (BPC_W'(box_idx_q) + BPC_W'(1)) >= n_box;
  assign cell_inc    = (CELL_W+1)'(cell_q) + (CELL_W+1)'(1);
  assign cell_total  = (CELL_W+1)'(side * side);
  assign box_no_full = BN_W'(cell_q) * BN_W'(n_box) + BN_W'(box_idx_q);

  // Dividers: cell index into row/column, and the two centre coordinates
  div_ctrl_t         cdiv_ctrl, xydiv_ctrl;
  logic              cdiv_done, xdiv_done, ydiv_done;
  logic [CELL_W-1:0] row;
  logic [SIDE_W-1:0] col;
  logic [PROD_W-1:0] qx, qy;
  logic [SIDE_W-1:0] rx_unused, ry_unused;

  assign cdiv_ctrl.start  = box_acc;
  assign xydiv_ctrl.start = (state_q == ST_MUL);

  ygbd_div #(.W(CELL_W), .DW(SIDE_W)) u_cell_div (
    .clk_i, .rst_ni,
    .ctrl_i      (cdiv_ctrl),
    .dividend_i  (cell_q),
    .divisor_i   (side),
    .done_o      (cdiv_done),
    .quotient_o  (row),
    .remainder_o (col)
  );

  ygbd_div #(.W(PROD_W), .DW(SIDE_W)) u_x_div (
    .clk_i, .rst_ni,
    .ctrl_i      (xydiv_ctrl),
    .dividend_i  (numx_q),
    .divisor_i   (side),
    .done_o      (xdiv_done),
    .quotient_o  (qx),
    .remainder_o (rx_unused)
  );

  ygbd_div #(.W(PROD_W), .DW(SIDE_W)) u_y_div (
    .clk_i, .rst_ni,
    .ctrl_i      (xydiv_ctrl),
    .dividend_i  (numy_q),
    .divisor_i   (side),
    .done_o      (ydiv_done),
    .quotient_o  (qy),
    .remainder_o (ry_unused)
  );

  // Control, configuration and output handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q    <= RST_CLASS_COUNT;
      boxes_per_cell_q <= RST_BOXES_PER_CELL;
      grid_side_q      <= RST_GRID_SIDE;
      square_mode_q    <= RST_SQUARE_MODE;
      threshold_q      <= RST_THRESHOLD;
      image_width_q    <= RST_IMAGE_WIDTH;
      image_height_q   <= RST_IMAGE_HEIGHT;
      only_obj_q       <= RST_ONLY_OBJ;
      state_q          <= ST_IDLE;
      load_cnt_q       <= '0;
      box_idx_q        <= '0;
      cell_q           <= '0;
      j_q              <= '0;
      s1_v_q           <= 1'b0;
      s2_v_q           <= 1'b0;
      out_v_q          <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CLASS_COUNT:     class_count_q    <= cfg_data_i[CLSCNT_W-1:0];
          REG_BOXES_PER_CELL:  boxes_per_cell_q <= cfg_data_i[BPC_W-1:0];
          REG_GRID_SIDE:       grid_side_q      <= cfg_data_i[GSIDE_W-1:0];
          REG_SQUARE_MODE:     square_mode_q    <= cfg_data_i[0];
          REG_THRESHOLD:       threshold_q      <= cfg_data_i[VAL_W-1:0];
          REG_IMAGE_WIDTH:     image_width_q    <= cfg_data_i[IMG_W-1:0];
          REG_IMAGE_HEIGHT:    image_height_q   <= cfg_data_i[IMG_W-1:0];
          REG_ONLY_OBJECTNESS: only_obj_q       <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (cls_acc && (load_cnt_q < LCW'(MAX_CLASSES))) begin
        load_cnt_q <= load_cnt_q + 1'b1;
      end

      // Advance box and cell counters as soon as the request is taken
      if (box_acc) begin
        if (box_wrap) begin
          box_idx_q  <= '0;
          load_cnt_q <= '0;
          cell_q     <= (cell_inc >= cell_total) ? '0 : cell_inc[CELL_W-1:0];
        end else begin
          box_idx_q <= box_idx_q + 1'b1;
        end
      end

      if (adv) begin
        s1_v_q  <= (state_q == ST_EMIT);
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end

      case (state_q)
        ST_IDLE: begin
          if (box_acc) state_q <= ST_CELL;
        end
        ST_CELL: begin
          if (cdiv_done) state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_XY;
        end
        ST_XY: begin
          if (xdiv_done) begin
            j_q     <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (adv) begin
            j_q <= j_q + 1'b1;
            if (last_issue) state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_v_q && !s2_v_q) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Class buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cls_acc && (load_cnt_q < LCW'(MAX_CLASSES))) begin
      class_mem[CIW'(load_cnt_q)] <= class_prob_i;
    end
    if (adv) begin
      rd_data_q <= class_mem[CIW'(j_q)];
    end
  end

  always_comb begin
    prob_raw = prod_q[SZ_W-1:VAL_W];
    prob_sel = (prob_raw > threshold_q) ? prob_raw : '0;
    if ((s2_j_q == '0) && only_obj_q) prob_sel = scale_q;
  end

  // Box datapath and result pipeline
  always_ff @(posedge clk_i) begin
    if (box_acc) begin
      scale_q  <= objectness_i;
      offx_q   <= offset_x_i;
      offy_q   <= offset_y_i;
      raww_q   <= raw_width_i;
      rawh_q   <= raw_height_i;
      box_no_q <= BOXNO_W'(box_no_full);
    end

    if ((state_q == ST_CELL) && cdiv_done) begin
      numx_q <= PROD_W'({CELL_W'(col), offx_q}) * PROD_W'(image_width_q);
      numy_q <= PROD_W'({row, offy_q}) * PROD_W'(image_height_q);
      szw_q  <= square_mode_q ? SZ_W'(raww_q) * SZ_W'(raww_q) : {raww_q, {VAL_W{1'b0}}};
      szh_q  <= square_mode_q ? SZ_W'(rawh_q) * SZ_W'(rawh_q) : {rawh_q, {VAL_W{1'b0}}};
    end

    if (state_q == ST_MUL) begin
      bw_q <= COORD_W'((SZP_W'(szw_q) * SZP_W'(image_width_q)) >> VAL_W);
      bh_q <= COORD_W'((SZP_W'(szh_q) * SZP_W'(image_height_q)) >> VAL_W);
    end

    if ((state_q == ST_XY) && xdiv_done && ydiv_done) begin
      cx_q <= qx[COORD_W-1:0];
      cy_q <= qy[COORD_W-1:0];
    end

    if (adv) begin
      s1_j_q    <= j_q;
      s1_last_q <= last_issue;
      s2_j_q    <= s1_j_q;
      s2_last_q <= s1_last_q;
      prod_q    <= SZ_W'(scale_q) * SZ_W'(rd_data_q);
      if (s2_v_q) begin
        o_box_no_q <= box_no_q;
        o_cx_q     <= cx_q;
        o_cy_q     <= cy_q;
        o_bw_q     <= bw_q;
        o_bh_q     <= bh_q;
        o_cls_q    <= s2_j_q;
        o_prob_q   <= prob_sel;
        o_last_q   <= s2_last_q;
      end
    end
  end

  assign out_valid_o    = out_v_q;
  assign box_number_o   = o_box_no_q;
  assign centre_x_o     = o_cx_q;
  assign centre_y_o     = o_cy_q;
  assign box_width_o    = o_bw_q;
  assign box_height_o   = o_bh_q;
  assign class_number_o = o_cls_q;
  assign probability_o  = o_prob_q;
  assign last_o         = o_last_q;

endmodule

`default_nettype wire
